### sv/egcd_pkg.sv
// Shared types and constants for the extended Euclidean gcd and modular inverse core.
package egcd_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int COEF_BITS    = OPERAND_BITS + 1;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);

    typedef struct packed {
        logic [OPERAND_BITS-1:0] value_a;
        logic [OPERAND_BITS-1:0] modulus;
    } egcd_in_t;

    typedef struct packed {
        logic [OPERAND_BITS-1:0]        gcd_value;
        logic signed [COEF_BITS-1:0]    bezout_s;
        logic signed [COEF_BITS-1:0]    bezout_t;
        logic [OPERAND_BITS-1:0]        inverse;
        logic                           has_inverse;
    } egcd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_FIN
    } egcd_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic finish;
    } egcd_cmd_t;

    typedef struct packed {
        logic r1_zero;
    } egcd_status_t;

endpackage

### sv/egcd_ctrl.sv
// Sequencer for the Euclid steps, the serial division and the result handoff.
module egcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_cmd_t   cmd
);

    localparam logic [egcd_pkg::CNT_BITS-1:0] DIV_LAST =
        egcd_pkg::CNT_BITS'(egcd_pkg::OPERAND_BITS - 1);

    egcd_pkg::egcd_state_t state_reg, state_next;
    logic [egcd_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egcd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = egcd_pkg::ST_CHECK;
                end
            end
            egcd_pkg::ST_CHECK:
            begin
                if (status.r1_zero)
                begin
                    state_next = egcd_pkg::ST_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = egcd_pkg::ST_DIV;
                end
            end
            egcd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = egcd_pkg::ST_UPD;
                end
            end
            egcd_pkg::ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = egcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.finish;
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == egcd_pkg::ST_CHECK)
        else $error("Accepted transaction did not start a Euclid step check.");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == egcd_pkg::ST_DIV && cnt_reg == DIV_LAST |=> state_reg == egcd_pkg::ST_UPD)
        else $error("Serial division did not end after the last quotient bit.");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("Finished result was not presented.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg || out_ready)
        else $error("Result register overwritten before its transaction.");
`endif

endmodule

### sv/egcd_dp.sv
// Datapath with remainder and coefficient registers, serial divider and result register.
module egcd_dp (
    input  logic                   clk,
    input  egcd_pkg::egcd_in_t     in_data,
    input  egcd_pkg::egcd_cmd_t    cmd,
    output egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_out_t    out_data
);

    localparam int N = egcd_pkg::OPERAND_BITS;
    localparam int C = egcd_pkg::COEF_BITS;

    logic [N-1:0] r0_reg, r1_reg, m_reg, dvd_reg, rem_reg;
    logic [C-1:0] s0_reg, s1_reg, t0_reg, t1_reg, acc_s_reg, acc_t_reg;
    egcd_pkg::egcd_out_t res_reg;

    logic [N:0]   shifted, trial;
    logic         qbit;
    logic [N-1:0] rem_next;
    logic [C-1:0] acc_s_next, acc_t_next;

    logic [C-1:0] m_ext, inv_sum, inv_diff, inv_full;
    logic         s_neg, s_ge, ok;

    always_comb
    begin
        shifted    = {rem_reg, dvd_reg[N-1]};
        trial      = shifted - {1'b0, r1_reg};
        qbit       = !trial[N];
        rem_next   = qbit ? trial[N-1:0] : shifted[N-1:0];
        acc_s_next = {acc_s_reg[C-2:0], 1'b0} + (qbit ? s1_reg : '0);
        acc_t_next = {acc_t_reg[C-2:0], 1'b0} + (qbit ? t1_reg : '0);
    end

    always_comb
    begin
        m_ext    = {1'b0, m_reg};
        s_neg    = s0_reg[C-1];
        s_ge     = !s_neg && (s0_reg >= m_ext);
        inv_sum  = s0_reg + m_ext;
        inv_diff = s0_reg - m_ext;
        inv_full = s_neg ? inv_sum : (s_ge ? inv_diff : s0_reg);
        ok       = (r0_reg == N'(1)) && (m_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r0_reg <= in_data.value_a;
            r1_reg <= in_data.modulus;
            m_reg  <= in_data.modulus;
            s0_reg <= C'(1);
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= C'(1);
        end
        else if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg - acc_s_reg;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - acc_t_reg;
        end

        if (cmd.div_start)
        begin
            dvd_reg   <= r0_reg;
            rem_reg   <= '0;
            acc_s_reg <= '0;
            acc_t_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg   <= {dvd_reg[N-2:0], 1'b0};
            rem_reg   <= rem_next;
            acc_s_reg <= acc_s_next;
            acc_t_reg <= acc_t_next;
        end

        if (cmd.finish)
        begin
            res_reg.gcd_value   <= r0_reg;
            res_reg.bezout_s    <= s0_reg;
            res_reg.bezout_t    <= t0_reg;
            res_reg.inverse     <= ok ? inv_full[N-1:0] : '0;
            res_reg.has_inverse <= ok;
        end
    end

    assign status.r1_zero = (r1_reg == '0);
    assign out_data       = res_reg;

endmodule

### sv/extended_gcd_modular_inverse_core.sv
// Top level of the extended Euclidean gcd and modular inverse core.
// Each input transaction carries a value and a modulus; the core returns the gcd, the Bezout
// coefficients s and t with s*value_a + t*modulus = gcd, and the inverse of value_a modulo
// modulus when the gcd is 1 and the modulus is not zero. Each Euclid step runs a restoring
// divider one quotient bit per cycle, accumulating quotient times s and t alongside, and one item
// is worked on at a time. The result register lets the next transaction start while a result waits.
module extended_gcd_modular_inverse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  egcd_pkg::egcd_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output egcd_pkg::egcd_out_t out_data
);

    egcd_pkg::egcd_cmd_t    cmd;
    egcd_pkg::egcd_status_t status;

    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    egcd_dp u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
